// ===== rtl/fat12te_pkg.sv =====
// ============================================================================
// fat12te_pkg: shared types and constants of the FAT12 table engine
// Operation, status and register codes, reset values, and the structs that
// run between the controller and the top level.
// ============================================================================
package fat12te_pkg;

    localparam int KIND_W      = 3;
    localparam int ENTRY_W     = 12;
    localparam int DATA_W      = 12;
    localparam int STATUS_W    = 2;
    localparam int BYTE_ADDR_W = 11;
    localparam int COUNT_W     = 7;
    localparam int SEARCH_W    = 11;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_W       = 12;
    localparam int CMP_W       = 13;

    localparam logic [KIND_W-1:0] KIND_GET   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SET   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FIND  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RBYTE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SHORT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_END = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY0     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY1     = 2'd2;

    localparam logic [SEARCH_W-1:0] RST_SEARCH_END = 11'd1013;
    localparam logic [ENTRY_W-1:0]  RST_ENTRY0     = 12'd4094;
    localparam logic [ENTRY_W-1:0]  RST_ENTRY1     = 12'd4095;

    typedef struct packed {
        logic [SEARCH_W-1:0] search_end;
        logic [ENTRY_W-1:0]  entry0_init;
        logic [ENTRY_W-1:0]  entry1_init;
    } cfg_t;

    typedef struct packed {
        logic                vld;
        logic [DATA_W-1:0]   data;
        logic [STATUS_W-1:0] status;
        logic                last;
    } emit_t;

    // Byte written by a clear: bytes 0..2 carry entries 0 and 1, rest zero.
    function automatic logic [7:0] clear_byte(input logic [1:0] sel,
                                              input logic [ENTRY_W-1:0] e0,
                                              input logic [ENTRY_W-1:0] e1);
        logic [7:0] b;
        unique case (sel)
            2'd0: b = e0[7:0];
            2'd1: b = {e1[3:0], e0[11:8]};
            2'd2: b = e1[11:4];
            2'd3: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/fat12te_ram.sv =====
// ============================================================================
// fat12te_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data registered, held while idle.
// ============================================================================
module fat12te_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1536,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/fat12te_ctrl.sv =====
// ============================================================================
// fat12te_ctrl: operation sequencer of the FAT12 table engine
// Byte-level read-modify-write on the packed table, the streaming free
// search with its hit buffer, and the clear sweep.
// ============================================================================
module fat12te_ctrl #(
    parameter int NUM_ENTRIES = 1024,
    parameter int MAX_RUN = 64,
    localparam int TABLE_BYTES = (NUM_ENTRIES * 3 + 1) / 2,
    localparam int TBL_AW = $clog2(TABLE_BYTES),
    localparam int HIT_AW = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [fat12te_pkg::KIND_W-1:0]        kind,
    input  logic [fat12te_pkg::ENTRY_W-1:0]       index,
    input  logic [fat12te_pkg::BYTE_ADDR_W-1:0]   byte_addr,
    input  logic [fat12te_pkg::ENTRY_W-1:0]       value,
    input  logic [fat12te_pkg::COUNT_W-1:0]       count,
    input  fat12te_pkg::cfg_t                     cfg,
    input  logic                                  out_free,
    output fat12te_pkg::emit_t                    emit,
    output logic                                  tbl_rd_en,
    output logic [TBL_AW-1:0]                     tbl_rd_addr,
    input  logic [7:0]                            tbl_rd_data,
    output logic                                  tbl_wr_en,
    output logic [TBL_AW-1:0]                     tbl_wr_addr,
    output logic [7:0]                            tbl_wr_data,
    output logic                                  hit_rd_en,
    output logic [HIT_AW-1:0]                     hit_rd_addr,
    input  logic [fat12te_pkg::ENTRY_W-1:0]       hit_rd_data,
    output logic                                  hit_wr_en,
    output logic [HIT_AW-1:0]                     hit_wr_addr,
    output logic [fat12te_pkg::ENTRY_W-1:0]       hit_wr_data
);

    import fat12te_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLR   = 4'd1;
    localparam logic [3:0] S_G0    = 4'd2;
    localparam logic [3:0] S_G1    = 4'd3;
    localparam logic [3:0] S_G2    = 4'd4;
    localparam logic [3:0] S_S0    = 4'd5;
    localparam logic [3:0] S_S1    = 4'd6;
    localparam logic [3:0] S_S2    = 4'd7;
    localparam logic [3:0] S_B0    = 4'd8;
    localparam logic [3:0] S_B1    = 4'd9;
    localparam logic [3:0] S_SCAN  = 4'd10;
    localparam logic [3:0] S_EMRD  = 4'd11;
    localparam logic [3:0] S_EMOUT = 4'd12;
    localparam logic [3:0] S_PUT   = 4'd13;

    // control state
    logic [3:0]          state_reg, state_next;
    logic                init_reg, init_next;
    logic                dvld_reg, dvld_next;
    logic [1:0]          phase_reg, phase_next;
    logic [TBL_AW-1:0]   ptr_reg, ptr_next;
    logic [ENTRY_W-1:0]  scan_pos_reg, scan_pos_next;
    logic [COUNT_W-1:0]  found_reg, found_next;
    logic [COUNT_W-1:0]  want_reg, want_next;
    logic [COUNT_W-1:0]  k_reg, k_next;
    // payload
    logic                odd_reg, odd_next;
    logic [TBL_AW-1:0]   base_reg, base_next;
    logic [ENTRY_W-1:0]  val_reg, val_next;
    logic [7:0]          lo_reg, lo_next;
    logic [DATA_W-1:0]   res_data_reg, res_data_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;

    logic                idx_bad;
    logic                addr_bad;
    logic [CMP_W:0]      base_sum;
    logic [TBL_AW-1:0]   base_in;
    logic [COUNT_W-1:0]  want_in;
    logic [CMP_W-1:0]    search_lim;
    logic [CMP_W-1:0]    end_eff;
    logic                run;
    logic [ENTRY_W-1:0]  entry_val;
    logic                entry_chk;
    logic [1:0]          clr_sel;
    logic                emit_last;

    always_comb
    begin
        idx_bad    = {1'b0, index} >= CMP_W'(NUM_ENTRIES);
        addr_bad   = {2'b00, byte_addr} >= CMP_W'(TABLE_BYTES);
        // 3 * (index / 2)
        base_sum   = {2'b00, index[ENTRY_W-1:1], 1'b0} + {3'b000, index[ENTRY_W-1:1]};
        base_in    = TBL_AW'(base_sum);
        if (count == '0)
        begin
            want_in = COUNT_W'(1);
        end
        else if (count > COUNT_W'(MAX_RUN))
        begin
            want_in = COUNT_W'(MAX_RUN);
        end
        else
        begin
            want_in = count;
        end
        search_lim = {2'b00, cfg.search_end};
        end_eff    = (search_lim > CMP_W'(NUM_ENTRIES)) ? CMP_W'(NUM_ENTRIES) : search_lim;
        run        = ({1'b0, scan_pos_reg} < end_eff) && (found_reg < want_reg);
        clr_sel    = (ptr_reg < TBL_AW'(3)) ? ptr_reg[1:0] : 2'd3;
        emit_last  = (k_reg + COUNT_W'(1)) == found_reg;
    end

    always_comb
    begin
        state_next      = state_reg;
        init_next       = init_reg;
        dvld_next       = dvld_reg;
        phase_next      = phase_reg;
        ptr_next        = ptr_reg;
        scan_pos_next   = scan_pos_reg;
        found_next      = found_reg;
        want_next       = want_reg;
        k_next          = k_reg;
        odd_next        = odd_reg;
        base_next       = base_reg;
        val_next        = val_reg;
        lo_next         = lo_reg;
        res_data_next   = res_data_reg;
        res_status_next = res_status_reg;

        in_ready    = (state_reg == S_IDLE);
        emit        = '0;
        tbl_rd_en   = 1'b0;
        tbl_rd_addr = ptr_reg;
        tbl_wr_en   = 1'b0;
        tbl_wr_addr = ptr_reg;
        tbl_wr_data = 8'h00;
        hit_rd_en   = 1'b0;
        hit_rd_addr = k_reg[HIT_AW-1:0];
        hit_wr_en   = 1'b0;
        hit_wr_addr = found_reg[HIT_AW-1:0];
        hit_wr_data = scan_pos_reg;
        entry_val   = '0;
        entry_chk   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    odd_next  = index[0];
                    base_next = base_in;
                    val_next  = value;
                    unique case (kind)
                        KIND_GET, KIND_SET:
                        begin
                            if (idx_bad)
                            begin
                                res_data_next   = '0;
                                res_status_next = ST_RANGE;
                                state_next      = S_PUT;
                            end
                            else
                            begin
                                state_next = (kind == KIND_GET) ? S_G0 : S_S0;
                            end
                        end
                        KIND_FIND:
                        begin
                            want_next     = want_in;
                            found_next    = '0;
                            scan_pos_next = ENTRY_W'(2);
                            ptr_next      = TBL_AW'(3);
                            phase_next    = 2'd0;
                            dvld_next     = 1'b0;
                            state_next    = S_SCAN;
                        end
                        KIND_RBYTE:
                        begin
                            base_next = TBL_AW'(byte_addr);
                            if (addr_bad)
                            begin
                                res_data_next   = '0;
                                res_status_next = ST_RANGE;
                                state_next      = S_PUT;
                            end
                            else
                            begin
                                state_next = S_B0;
                            end
                        end
                        KIND_CLEAR:
                        begin
                            ptr_next   = '0;
                            state_next = S_CLR;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_CLR:
            begin
                tbl_wr_en   = 1'b1;
                tbl_wr_data = init_reg ? clear_byte(clr_sel, RST_ENTRY0, RST_ENTRY1)
                                       : clear_byte(clr_sel, cfg.entry0_init,
                                                    cfg.entry1_init);
                ptr_next    = ptr_reg + TBL_AW'(1);
                if (ptr_reg == TBL_AW'(TABLE_BYTES - 1))
                begin
                    ptr_next  = '0;
                    init_next = 1'b0;
                    if (init_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        res_data_next   = '0;
                        res_status_next = ST_OK;
                        state_next      = S_PUT;
                    end
                end
            end

            S_G0:
            begin
                tbl_rd_en   = 1'b1;
                tbl_rd_addr = odd_reg ? base_reg + TBL_AW'(1) : base_reg;
                state_next  = S_G1;
            end

            S_G1:
            begin
                lo_next     = tbl_rd_data;
                tbl_rd_en   = 1'b1;
                tbl_rd_addr = odd_reg ? base_reg + TBL_AW'(2) : base_reg + TBL_AW'(1);
                state_next  = S_G2;
            end

            S_G2:
            begin
                if (out_free)
                begin
                    emit.vld    = 1'b1;
                    emit.data   = odd_reg ? {tbl_rd_data, lo_reg[7:4]}
                                          : {tbl_rd_data[3:0], lo_reg};
                    emit.status = ST_OK;
                    emit.last   = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            S_S0:
            begin
                tbl_rd_en   = 1'b1;
                tbl_rd_addr = base_reg + TBL_AW'(1);
                state_next  = S_S1;
            end

            S_S1:
            begin
                // shared middle byte arrives; write the byte owned alone
                lo_next     = tbl_rd_data;
                tbl_wr_en   = 1'b1;
                tbl_wr_addr = odd_reg ? base_reg + TBL_AW'(2) : base_reg;
                tbl_wr_data = odd_reg ? val_reg[11:4] : val_reg[7:0];
                state_next  = S_S2;
            end

            S_S2:
            begin
                tbl_wr_en       = 1'b1;
                tbl_wr_addr     = base_reg + TBL_AW'(1);
                tbl_wr_data     = odd_reg ? {val_reg[3:0], lo_reg[3:0]}
                                          : {lo_reg[7:4], val_reg[11:8]};
                res_data_next   = val_reg;
                res_status_next = ST_OK;
                state_next      = S_PUT;
            end

            S_B0:
            begin
                tbl_rd_en   = 1'b1;
                tbl_rd_addr = base_reg;
                state_next  = S_B1;
            end

            S_B1:
            begin
                if (out_free)
                begin
                    emit.vld    = 1'b1;
                    emit.data   = {4'h0, tbl_rd_data};
                    emit.status = ST_OK;
                    emit.last   = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            S_SCAN:
            begin
                if (run)
                begin
                    // bytes stream one per cycle; phase tracks position in a pair
                    tbl_rd_en   = 1'b1;
                    tbl_rd_addr = ptr_reg;
                    ptr_next    = ptr_reg + TBL_AW'(1);
                    dvld_next   = 1'b1;
                    if (dvld_reg)
                    begin
                        unique case (phase_reg)
                            2'd0:
                            begin
                                lo_next    = tbl_rd_data;
                                phase_next = 2'd1;
                            end
                            2'd1:
                            begin
                                lo_next    = tbl_rd_data;
                                entry_val  = {tbl_rd_data[3:0], lo_reg};
                                entry_chk  = 1'b1;
                                phase_next = 2'd2;
                            end
                            2'd2:
                            begin
                                entry_val  = {tbl_rd_data, lo_reg[7:4]};
                                entry_chk  = 1'b1;
                                phase_next = 2'd0;
                            end
                            default:
                            begin
                                phase_next = 2'd0;
                            end
                        endcase
                    end
                    if (entry_chk)
                    begin
                        scan_pos_next = scan_pos_reg + ENTRY_W'(1);
                        if (entry_val == '0)
                        begin
                            hit_wr_en  = 1'b1;
                            found_next = found_reg + COUNT_W'(1);
                        end
                    end
                end
                else if (found_reg == want_reg)
                begin
                    k_next     = '0;
                    state_next = S_EMRD;
                end
                else
                begin
                    res_data_next   = DATA_W'(found_reg);
                    res_status_next = ST_SHORT;
                    state_next      = S_PUT;
                end
            end

            S_EMRD:
            begin
                hit_rd_en  = 1'b1;
                state_next = S_EMOUT;
            end

            S_EMOUT:
            begin
                if (out_free)
                begin
                    emit.vld    = 1'b1;
                    emit.data   = hit_rd_data;
                    emit.status = ST_OK;
                    emit.last   = emit_last;
                    k_next      = k_reg + COUNT_W'(1);
                    state_next  = emit_last ? S_IDLE : S_EMRD;
                end
            end

            S_PUT:
            begin
                if (out_free)
                begin
                    emit.vld    = 1'b1;
                    emit.data   = res_data_reg;
                    emit.status = res_status_reg;
                    emit.last   = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // reset starts the clearing pass over the table
            state_reg    <= S_CLR;
            init_reg     <= 1'b1;
            dvld_reg     <= 1'b0;
            phase_reg    <= 2'd0;
            ptr_reg      <= '0;
            scan_pos_reg <= ENTRY_W'(2);
            found_reg    <= '0;
            want_reg     <= COUNT_W'(1);
            k_reg        <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            init_reg     <= init_next;
            dvld_reg     <= dvld_next;
            phase_reg    <= phase_next;
            ptr_reg      <= ptr_next;
            scan_pos_reg <= scan_pos_next;
            found_reg    <= found_next;
            want_reg     <= want_next;
            k_reg        <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        odd_reg        <= odd_next;
        base_reg       <= base_next;
        val_reg        <= val_next;
        lo_reg         <= lo_next;
        res_data_reg   <= res_data_next;
        res_status_reg <= res_status_next;
    end

endmodule

// ===== rtl/fat12_table_engine.sv =====
// ============================================================================
// fat12_table_engine: FAT12 allocation table engine
// Packed 12-bit table in byte RAM with get, set, free-entry search, raw byte
// read and clear; results leave through a registered output stage.
// ============================================================================
//
//   channel   signals                                       transfer when
//   -------   -------------------------------------------   -------------------
//   input     in_valid/in_ready, kind index byte_addr        in_valid & in_ready
//             value count
//   output    out_valid/out_ready, data status last          out_valid & out_ready
//   config    cfg_we, cfg_index, cfg_data                    cfg_we
//
// One item at a time. The single byte read and write ports of the table
// RAM set the pace: get reads two bytes, read byte reads one, set reads one
// and writes two, clear writes every byte (one byte written a cycle).
// Find streams one byte a cycle, then reads each index back from the hit RAM
// before it is emitted.
// After reset the table of TABLE_BYTES bytes (1536 by default) is swept once;
// in_ready stays low meanwhile. A stalled output holds the next result back.
//
module fat12_table_engine #(
    parameter int NUM_ENTRIES = 1024,
    parameter int MAX_RUN = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [fat12te_pkg::KIND_W-1:0]      kind,
    input  logic [fat12te_pkg::ENTRY_W-1:0]     index,
    input  logic [fat12te_pkg::BYTE_ADDR_W-1:0] byte_addr,
    input  logic [fat12te_pkg::ENTRY_W-1:0]     value,
    input  logic [fat12te_pkg::COUNT_W-1:0]     count,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [fat12te_pkg::DATA_W-1:0]      data,
    output logic [fat12te_pkg::STATUS_W-1:0]    status,
    output logic                                last,
    input  logic                                cfg_we,
    input  logic [fat12te_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fat12te_pkg::CFG_W-1:0]       cfg_data
);

    import fat12te_pkg::*;

    localparam int TABLE_BYTES = (NUM_ENTRIES * 3 + 1) / 2;
    localparam int TBL_AW = $clog2(TABLE_BYTES);
    localparam int HIT_AW = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;

    cfg_t                cfg_reg;
    emit_t               emit;
    logic                out_free;
    logic                out_valid_reg;
    logic [DATA_W-1:0]   data_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                last_reg;

    logic                tbl_rd_en;
    logic [TBL_AW-1:0]   tbl_rd_addr;
    logic [7:0]          tbl_rd_data;
    logic                tbl_wr_en;
    logic [TBL_AW-1:0]   tbl_wr_addr;
    logic [7:0]          tbl_wr_data;
    logic                hit_rd_en;
    logic [HIT_AW-1:0]   hit_rd_addr;
    logic [ENTRY_W-1:0]  hit_rd_data;
    logic                hit_wr_en;
    logic [HIT_AW-1:0]   hit_wr_addr;
    logic [ENTRY_W-1:0]  hit_wr_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.search_end  <= RST_SEARCH_END;
            cfg_reg.entry0_init <= RST_ENTRY0;
            cfg_reg.entry1_init <= RST_ENTRY1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SEARCH_END: cfg_reg.search_end  <= cfg_data[SEARCH_W-1:0];
                CFG_ENTRY0:     cfg_reg.entry0_init <= cfg_data[ENTRY_W-1:0];
                CFG_ENTRY1:     cfg_reg.entry1_init <= cfg_data[ENTRY_W-1:0];
                default:        cfg_reg             <= cfg_reg;
            endcase
        end
    end

    fat12te_ctrl #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .MAX_RUN     (MAX_RUN)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .index       (index),
        .byte_addr   (byte_addr),
        .value       (value),
        .count       (count),
        .cfg         (cfg_reg),
        .out_free    (out_free),
        .emit        (emit),
        .tbl_rd_en   (tbl_rd_en),
        .tbl_rd_addr (tbl_rd_addr),
        .tbl_rd_data (tbl_rd_data),
        .tbl_wr_en   (tbl_wr_en),
        .tbl_wr_addr (tbl_wr_addr),
        .tbl_wr_data (tbl_wr_data),
        .hit_rd_en   (hit_rd_en),
        .hit_rd_addr (hit_rd_addr),
        .hit_rd_data (hit_rd_data),
        .hit_wr_en   (hit_wr_en),
        .hit_wr_addr (hit_wr_addr),
        .hit_wr_data (hit_wr_data)
    );

    fat12te_ram #(
        .WIDTH (8),
        .DEPTH (TABLE_BYTES)
    ) u_table_ram (
        .clk     (clk),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    // indices of the free entries found by a search, read back once enough are found
    fat12te_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_RUN)
    ) u_hit_ram (
        .clk     (clk),
        .wr_en   (hit_wr_en),
        .wr_addr (hit_wr_addr),
        .wr_data (hit_wr_data),
        .rd_en   (hit_rd_en),
        .rd_addr (hit_rd_addr),
        .rd_data (hit_rd_data)
    );

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit.vld)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.vld)
        begin
            data_reg   <= emit.data;
            status_reg <= emit.status;
            last_reg   <= emit.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign data      = data_reg;
    assign status    = status_reg;
    assign last      = last_reg;

endmodule

// ===== rtl/fat12te_checker.sv =====
// ============================================================================
// fat12te_checker: port-level assertions for the FAT12 table engine
// Watches the top-level ports only; attached by bind.
// ============================================================================
module fat12te_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic [fat12te_pkg::KIND_W-1:0]      kind,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic [fat12te_pkg::DATA_W-1:0]      data,
    input logic [fat12te_pkg::STATUS_W-1:0]    status,
    input logic                                last
);

    import fat12te_pkg::*;

    // a stalled result keeps its fields
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(data) && $stable(status)
                                    && $stable(last))
        else $error("result changed while stalled");

    // one item in flight: a known operation drops ready right after its transfer
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && kind <= KIND_CLEAR |=> !in_ready)
        else $error("input taken while an item is in progress");

    // error and short-search results stand alone
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> last)
        else $error("error result not marked last");

    a_mid_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> status == ST_OK)
        else $error("non-final result with error status");

    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_RANGE |-> data == '0)
        else $error("range error with nonzero data");

endmodule

bind fat12_table_engine fat12te_checker u_fat12te_checker (.*);
